/* rtl/rlbbm_pkg.sv */
// Package for the break-before-make relay level switch.
// Holds the phase type, item codes, register indexes and the status struct.
// No dependencies.
package rlbbm_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int LEVEL_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADTIME    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH = 2'd2;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic [1:0] LVL_OFF    = 2'd0;
    localparam logic [1:0] LVL_LOW    = 2'd1;
    localparam logic [1:0] LVL_MEDIUM = 2'd2;
    localparam logic [1:0] LVL_HIGH   = 2'd3;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PENDING = 2'd1,
        PH_DEAD    = 2'd2
    } t_phase;

    typedef struct packed {
        logic [1:0] active;
        t_phase     phase;
    } t_status;

endpackage

/* rtl/rlbbm_if.sv */
// Handshake interfaces for request/tick items and result items.
// Depends on rlbbm_pkg for field widths.
interface rlbbm_in_if import rlbbm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [LEVEL_W-1:0] level;

    modport source (output valid, opcode, level, input ready);
    modport sink (input valid, opcode, level, output ready);
endinterface

interface rlbbm_out_if;
    logic       valid;
    logic       ready;
    logic       relay_low;
    logic       relay_medium;
    logic       relay_high;
    logic [1:0] active_level;
    logic [1:0] phase;

    modport source (output valid, relay_low, relay_medium, relay_high, active_level, phase,
                    input ready);
    modport sink (input valid, relay_low, relay_medium, relay_high, active_level, phase,
                  output ready);
endinterface

/* rtl/rlbbm_core.sv */
// Phase state machine and shared saturating elapsed-tick timer.
// Depends on rlbbm_pkg; produces the state that follows each accepted item.
module rlbbm_core import rlbbm_pkg::*; #(
    parameter int TIMER_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_opcode,
    input  logic [LEVEL_W-1:0] i_level,
    input  logic [CFG_W-1:0]   i_debounce,
    input  logic [CFG_W-1:0]   i_deadtime,
    output t_status            o_next
);

    localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    t_phase                r_phase, n_phase;
    logic [1:0]            r_active, n_active;
    logic [1:0]            r_requested, n_requested;
    logic [1:0]            r_committed, n_committed;
    logic [TIMER_BITS-1:0] r_elapsed, n_elapsed;

    logic [TIMER_BITS-1:0] inc;
    logic [1:0]            req_lvl;
    logic                  req_same;
    logic                  deb_done;
    logic                  dead_done;

    always_comb begin
        inc       = (r_elapsed != TIMER_MAX) ? r_elapsed + 1'b1 : r_elapsed;
        req_lvl   = (i_level > LEVEL_W'(LVL_HIGH)) ? LVL_OFF : i_level[1:0];
        req_same  = (r_phase == PH_PENDING) && (req_lvl == r_requested);
        deb_done  = CMP_W'(inc) >= CMP_W'(i_debounce);
        dead_done = CMP_W'(inc) >= CMP_W'(i_deadtime);
    end

    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            if (i_opcode == OP_REQUEST) begin
                if (!req_same) begin
                    n_phase = PH_PENDING;
                end
            end else begin
                unique case (r_phase)
                    PH_PENDING: begin
                        if (deb_done) begin
                            n_phase = (r_requested == r_active) ? PH_IDLE : PH_DEAD;
                        end
                    end
                    PH_DEAD: begin
                        if (dead_done) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: n_phase = r_phase;
                endcase
            end
        end
    end

    always_comb begin
        n_active    = r_active;
        n_requested = r_requested;
        n_committed = r_committed;
        n_elapsed   = r_elapsed;
        if (i_accept) begin
            if (i_opcode == OP_REQUEST) begin
                if (!req_same) begin
                    n_requested = req_lvl;
                    n_elapsed   = '0;
                end
            end else begin
                n_elapsed = inc;
                unique case (r_phase)
                    PH_PENDING: begin
                        if (deb_done && (r_requested != r_active)) begin
                            n_active    = LVL_OFF;
                            n_committed = r_requested;
                            n_elapsed   = '0;
                        end
                    end
                    PH_DEAD: begin
                        if (dead_done) begin
                            n_active = r_committed;
                        end
                    end
                    default: n_active = r_active;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_active    <= LVL_OFF;
            r_requested <= LVL_OFF;
            r_committed <= LVL_OFF;
            r_elapsed   <= '0;
        end else begin
            r_phase     <= n_phase;
            r_active    <= n_active;
            r_requested <= n_requested;
            r_committed <= n_committed;
            r_elapsed   <= n_elapsed;
        end
    end

    assign o_next.active = n_active;
    assign o_next.phase  = n_phase;

    // All relays stay open throughout dead time.
    a_dead_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DEAD) |-> (r_active == LVL_OFF))
        else $error("relay energised during dead time");

    // Every accepted request leaves the block pending.
    a_req_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_opcode == OP_REQUEST)) |=> (r_phase == PH_PENDING))
        else $error("request did not enter pending");

    // Dead time starts with a cleared timer.
    a_dead_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_phase == PH_DEAD) |-> (r_elapsed == '0))
        else $error("dead time entered with nonzero timer");

endmodule

/* rtl/rlbbm_out.sv */
// Result register: maps the new state to relay pins at the set polarity.
// Depends on rlbbm_pkg and rlbbm_out_if.
module rlbbm_out import rlbbm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_status       i_next,
    input  logic          i_active_high,
    output logic          o_space,
    rlbbm_out_if.source   o_result
);

    logic       r_valid;
    logic       r_relay_low;
    logic       r_relay_medium;
    logic       r_relay_high;
    logic [1:0] r_active;
    logic [1:0] r_phase;

    assign o_space = !r_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_relay_low    <= (i_next.active == LVL_LOW) == i_active_high;
            r_relay_medium <= (i_next.active == LVL_MEDIUM) == i_active_high;
            r_relay_high   <= (i_next.active == LVL_HIGH) == i_active_high;
            r_active       <= i_next.active;
            r_phase        <= i_next.phase;
        end
    end

    assign o_result.valid        = r_valid;
    assign o_result.relay_low    = r_relay_low;
    assign o_result.relay_medium = r_relay_medium;
    assign o_result.relay_high   = r_relay_high;
    assign o_result.active_level = r_active;
    assign o_result.phase        = r_phase;

endmodule

/* rtl/relay_level_break_before_make.sv */
// Top level of the break-before-make relay level switch with debounce.
// An accepted item's result is registered and appears on o_result in the cycle after it is accepted.
// Throughput: one item per cycle; the result register takes a new item whenever
// it is empty or its current result is taken in the same cycle.
// Reset is synchronous and active low; it restores idle phase and the off level, empties the result
// register, and restores the default debounce, dead-time and polarity registers.
module relay_level_break_before_make import rlbbm_pkg::*; #(
    parameter int TIMER_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    rlbbm_in_if.sink             i_item,
    rlbbm_out_if.source          o_result
);

    logic [CFG_W-1:0] r_debounce;
    logic [CFG_W-1:0] r_deadtime;
    logic             r_active_high;
    logic             space;
    logic             accept;
    t_status          next_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce    <= CFG_W'(500);
            r_deadtime    <= CFG_W'(100);
            r_active_high <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DEBOUNCE:    r_debounce    <= i_cfg_wdata;
                CFG_DEADTIME:    r_deadtime    <= i_cfg_wdata;
                CFG_ACTIVE_HIGH: r_active_high <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign i_item.ready = space;
    assign accept       = i_item.valid && space;

    rlbbm_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_opcode   (i_item.opcode),
        .i_level    (i_item.level),
        .i_debounce (r_debounce),
        .i_deadtime (r_deadtime),
        .o_next     (next_status)
    );

    rlbbm_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (accept),
        .i_next        (next_status),
        .i_active_high (r_active_high),
        .o_space       (space),
        .o_result      (o_result)
    );

endmodule
